FILE: rtl/srpq_pkg.sv
package srpq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 2;
    localparam int ENTRY_W = 40;
    localparam int OCC_W   = 5;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;
    localparam int STAT_W  = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Entries sort as plain unsigned words in this bit order.
    typedef struct packed {
        logic [15:0] rem_time;
        logic [15:0] parent_id;
        logic        is_sub;
        logic [6:0]  sub_index;
    } entry_t;

    function automatic logic [ENTRY_W-1:0] make_entry(input logic [IN_W-1:0] data);
        entry_t e;
        e.rem_time  = data[15:0];
        e.parent_id = data[31:16];
        e.is_sub    = data[32];
        e.sub_index = data[32] ? data[39:33] : 7'd0;
        return e;
    endfunction

    // Circular slot index: base plus an offset of at most DEPTH.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

endpackage

FILE: rtl/srpq_ram.sv
module srpq_ram #(
    parameter int DATA_W = 40,
    parameter int ADDR_W = 4,
    parameter int WORDS  = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/shortest_remaining_priority_queue.sv
// Channel  Dir  Handshake         Payload
// s        in   s_tvalid/s_tready s_tuser: mode; s_tdata: time, id, sub flag, sub index
// m        out  m_tvalid/m_tready m_tuser: status; m_tdata: popped entry, occupancy
//
// The queue is a circular buffer in one RAM, kept sorted from the head slot.
// A pop reads the head slot; its result passes through S_POP_RD and S_EMIT.
// A push walks back from the tail one slot a cycle, moving larger entries up;
// a push into an empty queue instead writes the head slot at acceptance and goes to S_EMIT.
// Refused items go straight to S_EMIT; s_tready returns in the same cycle as the result shows on m.
// A stalled result holds the next item back. Reset empties the queue at once.
module shortest_remaining_priority_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [srpq_pkg::IN_W-1:0]     s_tdata,  // rem_time, parent_id, is_subprocess, sub_index
    input  logic                          s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [srpq_pkg::OUT_W-1:0]    m_tdata,  // out_time, out_id, out_is_sub, out_sub_index, occupancy
    output logic [srpq_pkg::STAT_W-1:0]   m_tuser   // status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PLACE_HEAD,
        S_POP_RD,
        S_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [srpq_pkg::IDX_W-1:0]        head_reg, head_next;
    logic [srpq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [srpq_pkg::IDX_W-1:0]        j_reg, j_next;
    logic [srpq_pkg::ENTRY_W-1:0]      key_reg, key_next;
    logic [srpq_pkg::ENTRY_W-1:0]      entry_reg, entry_next;
    srpq_pkg::status_t                 status_reg, status_next;
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [srpq_pkg::OUT_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [srpq_pkg::STAT_W-1:0]       m_tuser_reg, m_tuser_next;

    logic                              ram_we;
    logic [srpq_pkg::IDX_W-1:0]        ram_waddr;
    logic [srpq_pkg::ENTRY_W-1:0]      ram_wdata;
    logic                              ram_re;
    logic [srpq_pkg::IDX_W-1:0]        ram_raddr;
    logic [srpq_pkg::ENTRY_W-1:0]      ram_rdata;

    logic                              in_fire;
    srpq_pkg::entry_t                  out_entry;

    srpq_ram #(
        .DATA_W (srpq_pkg::ENTRY_W),
        .ADDR_W (srpq_pkg::IDX_W),
        .WORDS  (srpq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign out_entry = srpq_pkg::entry_t'(entry_reg);

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        entry_next    = entry_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = key_reg;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next    = srpq_pkg::make_entry(s_tdata);
                    entry_next  = '0;
                    status_next = srpq_pkg::ST_OK;
                    if (s_tuser == srpq_pkg::MODE_PUSH)
                    begin
                        if (count_reg == srpq_pkg::CNT_W'(srpq_pkg::DEPTH))
                        begin
                            status_next = srpq_pkg::ST_FULL;
                            state_next  = S_EMIT;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg;
                            ram_wdata  = srpq_pkg::make_entry(s_tdata);
                            count_next = count_reg + 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = srpq_pkg::slot(head_reg, count_reg - 1'b1);
                            j_next     = srpq_pkg::IDX_W'(count_reg - 1'b1);
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = srpq_pkg::ST_EMPTY;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = S_POP_RD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = srpq_pkg::slot(head_reg, srpq_pkg::CNT_W'(j_reg) + 1'b1);
                if (ram_rdata > key_reg)
                begin
                    ram_wdata = ram_rdata;
                    if (j_reg == '0)
                    begin
                        state_next = S_PLACE_HEAD;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = srpq_pkg::slot(head_reg, srpq_pkg::CNT_W'(j_reg - 1'b1));
                        j_next     = j_reg - 1'b1;
                    end
                end
                else
                begin
                    ram_wdata  = key_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_PLACE_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = key_reg;
                count_next = count_reg + 1'b1;
                state_next = S_EMIT;
            end

            S_POP_RD:
            begin
                entry_next = ram_rdata;
                head_next  = srpq_pkg::slot(head_reg, srpq_pkg::CNT_W'(1));
                count_next = count_reg - 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {3'b000,
                                     srpq_pkg::OCC_W'(count_reg),
                                     out_entry.sub_index,
                                     out_entry.is_sub,
                                     out_entry.parent_id,
                                     out_entry.rem_time};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg       <= j_next;
        key_reg     <= key_next;
        entry_reg   <= entry_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
